/* sv/gcd_pkg.sv */
// Package for the great-circle distance block: field widths, fixed constants
// and the elaboration-time arctangent table for the CORDIC stages.
// Depends on nothing; every module of the block but gcd_umul_round imports it.
package gcd_pkg;

  localparam int LAT_W = 28;
  localparam int LON_W = 29;
  localparam int DIST_W = 31;
  localparam int SUM_W = 30;
  localparam int MAG_W = 28;
  localparam int GUARD_BITS = 8;
  localparam int CORDIC_ITERATIONS_DEFAULT = 32;
  localparam int ANGLE_FRACTION_BITS_DEFAULT = 30;
  localparam int RAD_W = 64;
  localparam int DIAM_W = 31;
  localparam int FINAL_W = 33;

  localparam logic signed [SUM_W-1:0] HALF_TURN_UNITS = 30'sd360000000;
  localparam logic signed [SUM_W-1:0] QUARTER_TURN_UNITS = 30'sd180000000;
  localparam logic [RAD_W-1:0] RAD_PER_UNIT_Q90 = 64'd10803064813898916640;
  localparam logic [DIAM_W-1:0] DIAMETER_CM = 31'd1274200000;
  localparam logic [FINAL_W-1:0] MAX_DISTANCE_CM = 33'd2001508680;

  // Series for atan(1/q) in Q62, with q = 2^lg or q = 3.
  function automatic logic [63:0] gcd_atan_recip(input int lg, input bit by_three);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    p = by_three ? 64'd1537228672809129301 : (64'd1 << 62) >> lg;
    sum = 64'd0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        term = p / 64'(2 * k + 1);
        sum = k[0] ? sum - term : sum + term;
        p = by_three ? p / 64'd9 : p >> (2 * lg);
      end
    end
    return sum;
  endfunction

  // atan(2^-i) rounded half up to w fraction bits.
  function automatic logic [63:0] gcd_atan_tab(input int i, input int w);
    logic [63:0] t;
    t = (i == 0) ? gcd_atan_recip(1, 1'b0) + gcd_atan_recip(0, 1'b1)
                 : gcd_atan_recip(i, 1'b0);
    return (t + (64'd1 << (61 - w))) >> (62 - w);
  endfunction

endpackage

/* sv/gcd_umul_round.sv */
// Two-stage unsigned multiplier from four partial products, rounded half up
// and shifted right by SHIFT. Depends on nothing beyond its parameters.
module gcd_umul_round #(
  parameter int AW = 28,
  parameter int BW = 64,
  parameter int OW = 31,
  parameter int SHIFT = 30
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic          out_valid,
  output logic [OW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW + 1;

  logic [AL+BL-1:0] pll;
  logic [AL+BH-1:0] plh;
  logic [AH+BL-1:0] phl;
  logic [AH+BH-1:0] phh;
  logic             mid_valid;
  logic [PW-1:0]    total;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    pll <= a[AL-1:0] * b[BL-1:0];
    plh <= a[AL-1:0] * b[BW-1:BL];
    phl <= a[AW-1:AL] * b[BL-1:0];
    phh <= a[AW-1:AL] * b[BW-1:BL];
    p <= total[SHIFT +: OW];
  end

  assign total = (PW'(phh) << (AL + BL)) + (PW'(plh) << BL) + (PW'(phl) << AL)
               + PW'(pll) + (PW'(1) << (SHIFT - 1));

endmodule

/* sv/gcd_angle_prep.sv */
// Angle preparation: reduces a half-microdegree angle into a quarter turn
// either side of zero and converts it to signed radians with guard bits.
// Depends on gcd_pkg and gcd_umul_round.
module gcd_angle_prep #(
  parameter int F = gcd_pkg::ANGLE_FRACTION_BITS_DEFAULT,
  parameter int DW = gcd_pkg::ANGLE_FRACTION_BITS_DEFAULT + gcd_pkg::GUARD_BITS + 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic signed [gcd_pkg::SUM_W-1:0] v,
  output logic                            out_valid,
  output logic signed [DW-1:0]            z
);
  import gcd_pkg::*;

  logic signed [SUM_W-1:0] r;
  logic [MAG_W-1:0]        mag;
  logic                    neg;
  logic                    neg_d1;
  logic                    neg_d2;
  logic                    s1_valid;
  logic                    th_valid;
  logic [F:0]              th;
  logic signed [DW-1:0]    th_ext;

  always_comb begin
    if (v > QUARTER_TURN_UNITS) begin
      r = v - HALF_TURN_UNITS;
    end else if (v <= -QUARTER_TURN_UNITS) begin
      r = v + HALF_TURN_UNITS;
    end else begin
      r = v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      out_valid <= th_valid;
    end
  end

  always_ff @(posedge clk) begin
    mag <= r[SUM_W-1] ? MAG_W'(-r) : MAG_W'(r);
    neg <= r[SUM_W-1];
    neg_d1 <= neg;
    neg_d2 <= neg_d1;
    z <= neg_d2 ? -th_ext : th_ext;
  end

  gcd_umul_round #(
    .AW(MAG_W), .BW(RAD_W), .OW(F + 1), .SHIFT(90 - F)
  ) u_scale (
    .clk(clk), .rst(rst), .in_valid(s1_valid), .a(mag), .b(RAD_PER_UNIT_Q90),
    .out_valid(th_valid), .p(th)
  );

  assign th_ext = DW'(th) <<< GUARD_BITS;

endmodule

/* sv/gcd_cordic_rotate.sv */
// Pipelined rotation CORDIC, one stage per iteration, from (2^W, 0).
// Gives sine and cosine with the uncompensated gain. Depends on gcd_pkg.
module gcd_cordic_rotate #(
  parameter int ITER = gcd_pkg::CORDIC_ITERATIONS_DEFAULT,
  parameter int W = gcd_pkg::ANGLE_FRACTION_BITS_DEFAULT + gcd_pkg::GUARD_BITS,
  parameter int DW = W + 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [DW-1:0] z,
  output logic                 out_valid,
  output logic signed [DW-1:0] s,
  output logic signed [DW-1:0] c
);
  import gcd_pkg::*;

  localparam logic signed [DW-1:0] ONE = DW'(1) <<< W;

  logic signed [DW-1:0] xs [ITER];
  logic signed [DW-1:0] ys [ITER];
  logic signed [DW-1:0] zs [ITER];
  logic                 vs [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    localparam logic signed [DW-1:0] ANG = DW'(gcd_atan_tab(i, W));
    logic signed [DW-1:0] xi;
    logic signed [DW-1:0] yi;
    logic signed [DW-1:0] zi;
    logic                 vi;
    if (i == 0) begin : g_first
      assign xi = ONE;
      assign yi = '0;
      assign zi = z;
      assign vi = in_valid;
    end else begin : g_next
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
      assign vi = vs[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i] <= 1'b0;
      end else begin
        vs[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (zi >= 0) begin
        xs[i] <= xi - (yi >>> i);
        ys[i] <= yi + (xi >>> i);
        zs[i] <= zi - ANG;
      end else begin
        xs[i] <= xi + (yi >>> i);
        ys[i] <= yi - (xi >>> i);
        zs[i] <= zi + ANG;
      end
    end
  end

  assign out_valid = vs[ITER-1];
  assign s = ys[ITER-1];
  assign c = xs[ITER-1];

endmodule

/* sv/gcd_cordic_vector.sv */
// Pipelined vectoring CORDIC, one stage per iteration, for x >= 0.
// Gives the magnitude with gain and the angle atan2(y, x). Depends on gcd_pkg.
module gcd_cordic_vector #(
  parameter int ITER = gcd_pkg::CORDIC_ITERATIONS_DEFAULT,
  parameter int W = gcd_pkg::ANGLE_FRACTION_BITS_DEFAULT + gcd_pkg::GUARD_BITS,
  parameter int DW = W + 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [DW-1:0] x,
  input  logic signed [DW-1:0] y,
  output logic                 out_valid,
  output logic signed [DW-1:0] mag,
  output logic signed [DW-1:0] ang
);
  import gcd_pkg::*;

  logic signed [DW-1:0] xs [ITER];
  logic signed [DW-1:0] ys [ITER];
  logic signed [DW-1:0] zs [ITER];
  logic                 vs [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    localparam logic signed [DW-1:0] ANG = DW'(gcd_atan_tab(i, W));
    logic signed [DW-1:0] xi;
    logic signed [DW-1:0] yi;
    logic signed [DW-1:0] zi;
    logic                 vi;
    if (i == 0) begin : g_first
      assign xi = x;
      assign yi = y;
      assign zi = '0;
      assign vi = in_valid;
    end else begin : g_next
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
      assign vi = vs[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i] <= 1'b0;
      end else begin
        vs[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (yi >= 0) begin
        xs[i] <= xi + (yi >>> i);
        ys[i] <= yi - (xi >>> i);
        zs[i] <= zi + ANG;
      end else begin
        xs[i] <= xi - (yi >>> i);
        ys[i] <= yi + (xi >>> i);
        zs[i] <= zi - ANG;
      end
    end
  end

  assign out_valid = vs[ITER-1];
  assign mag = xs[ITER-1];
  assign ang = zs[ITER-1];

endmodule

/* sv/great_circle_distance.sv */
// Haversine great-circle distance between two points in microdegrees.
// Three CORDIC pipelines lie in series; throughput is one item per clock.
// Busy stays low and the receiver cannot stall. Synchronous reset clears
// all valid bits; the datapath registers are not reset.
// Depends on gcd_pkg, gcd_angle_prep, gcd_cordic_rotate, gcd_cordic_vector
// and gcd_umul_round.
module great_circle_distance #(
  parameter int CORDIC_ITERATIONS = gcd_pkg::CORDIC_ITERATIONS_DEFAULT,
  parameter int ANGLE_FRACTION_BITS = gcd_pkg::ANGLE_FRACTION_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [gcd_pkg::LAT_W-1:0] first_latitude,
  input  logic signed [gcd_pkg::LON_W-1:0] first_longitude,
  input  logic signed [gcd_pkg::LAT_W-1:0] second_latitude,
  input  logic signed [gcd_pkg::LON_W-1:0] second_longitude,
  output logic                             done,
  output logic [gcd_pkg::DIST_W-1:0]       distance_cm
);
  import gcd_pkg::*;

  localparam int F = ANGLE_FRACTION_BITS;
  localparam int W = F + GUARD_BITS;
  localparam int DW = W + 5;

  logic                    in_valid;
  logic signed [SUM_W-1:0] v_lat;
  logic signed [SUM_W-1:0] v_lon;
  logic signed [SUM_W-1:0] v_mid;

  logic                 prep_valid;
  logic signed [DW-1:0] z_lat;
  logic signed [DW-1:0] z_lon;
  logic signed [DW-1:0] z_mid;

  logic                 rot_valid;
  logic signed [DW-1:0] s1;
  logic signed [DW-1:0] c1;
  logic signed [DW-1:0] s2;
  logic signed [DW-1:0] c2;
  logic signed [DW-1:0] sm;
  logic signed [DW-1:0] cm;

  logic            abs_valid;
  logic [DW-2:0]   s1_mag;
  logic [DW-2:0]   c1_mag;
  logic [DW-2:0]   s2_mag;
  logic [DW-2:0]   c2_mag;
  logic [DW-2:0]   sm_mag;
  logic [DW-2:0]   cm_mag;

  logic          prod_valid;
  logic [DW-2:0] p_s1c2;
  logic [DW-2:0] p_cms2;
  logic [DW-2:0] p_c1c2;
  logic [DW-2:0] p_sms2;

  logic                 vec_valid;
  logic signed [DW-1:0] ya;
  logic signed [DW-1:0] xa;

  logic                 ang_valid;
  logic signed [DW-1:0] ang;

  logic               clamp_valid;
  logic [W+1:0]       ang_pos;
  logic               dist_valid;
  logic [FINAL_W-1:0] dist_raw;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      abs_valid <= 1'b0;
      clamp_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      abs_valid <= rot_valid;
      clamp_valid <= ang_valid;
      done <= dist_valid;
    end
  end

  always_ff @(posedge clk) begin
    v_lat <= {{2{second_latitude[LAT_W-1]}}, second_latitude}
           - {{2{first_latitude[LAT_W-1]}}, first_latitude};
    v_lon <= {second_longitude[LON_W-1], second_longitude}
           - {first_longitude[LON_W-1], first_longitude};
    v_mid <= {{2{second_latitude[LAT_W-1]}}, second_latitude}
           + {{2{first_latitude[LAT_W-1]}}, first_latitude};
    s1_mag <= s1[DW-1] ? (DW-1)'(-s1) : s1[DW-2:0];
    c1_mag <= c1[DW-1] ? (DW-1)'(-c1) : c1[DW-2:0];
    s2_mag <= s2[DW-1] ? (DW-1)'(-s2) : s2[DW-2:0];
    c2_mag <= c2[DW-1] ? (DW-1)'(-c2) : c2[DW-2:0];
    sm_mag <= sm[DW-1] ? (DW-1)'(-sm) : sm[DW-2:0];
    cm_mag <= cm[DW-1] ? (DW-1)'(-cm) : cm[DW-2:0];
    ang_pos <= ang[DW-1] ? '0 : ang[W+1:0];
    distance_cm <= (dist_raw > MAX_DISTANCE_CM) ? DIST_W'(MAX_DISTANCE_CM)
                                                : dist_raw[DIST_W-1:0];
  end

  gcd_angle_prep #(.F(F), .DW(DW)) u_prep_lat (
    .clk(clk), .rst(rst), .in_valid(in_valid), .v(v_lat),
    .out_valid(prep_valid), .z(z_lat)
  );
  gcd_angle_prep #(.F(F), .DW(DW)) u_prep_lon (
    .clk(clk), .rst(rst), .in_valid(in_valid), .v(v_lon),
    .out_valid(), .z(z_lon)
  );
  gcd_angle_prep #(.F(F), .DW(DW)) u_prep_mid (
    .clk(clk), .rst(rst), .in_valid(in_valid), .v(v_mid),
    .out_valid(), .z(z_mid)
  );

  gcd_cordic_rotate #(.ITER(CORDIC_ITERATIONS), .W(W), .DW(DW)) u_rot_lat (
    .clk(clk), .rst(rst), .in_valid(prep_valid), .z(z_lat),
    .out_valid(rot_valid), .s(s1), .c(c1)
  );
  gcd_cordic_rotate #(.ITER(CORDIC_ITERATIONS), .W(W), .DW(DW)) u_rot_lon (
    .clk(clk), .rst(rst), .in_valid(prep_valid), .z(z_lon),
    .out_valid(), .s(s2), .c(c2)
  );
  gcd_cordic_rotate #(.ITER(CORDIC_ITERATIONS), .W(W), .DW(DW)) u_rot_mid (
    .clk(clk), .rst(rst), .in_valid(prep_valid), .z(z_mid),
    .out_valid(), .s(sm), .c(cm)
  );

  gcd_umul_round #(.AW(DW - 1), .BW(DW - 1), .OW(DW - 1), .SHIFT(W)) u_mul_s1c2 (
    .clk(clk), .rst(rst), .in_valid(abs_valid), .a(s1_mag), .b(c2_mag),
    .out_valid(prod_valid), .p(p_s1c2)
  );
  gcd_umul_round #(.AW(DW - 1), .BW(DW - 1), .OW(DW - 1), .SHIFT(W)) u_mul_cms2 (
    .clk(clk), .rst(rst), .in_valid(abs_valid), .a(cm_mag), .b(s2_mag),
    .out_valid(), .p(p_cms2)
  );
  gcd_umul_round #(.AW(DW - 1), .BW(DW - 1), .OW(DW - 1), .SHIFT(W)) u_mul_c1c2 (
    .clk(clk), .rst(rst), .in_valid(abs_valid), .a(c1_mag), .b(c2_mag),
    .out_valid(), .p(p_c1c2)
  );
  gcd_umul_round #(.AW(DW - 1), .BW(DW - 1), .OW(DW - 1), .SHIFT(W)) u_mul_sms2 (
    .clk(clk), .rst(rst), .in_valid(abs_valid), .a(sm_mag), .b(s2_mag),
    .out_valid(), .p(p_sms2)
  );

  gcd_cordic_vector #(.ITER(CORDIC_ITERATIONS), .W(W), .DW(DW)) u_vec_sin (
    .clk(clk), .rst(rst), .in_valid(prod_valid),
    .x({1'b0, p_s1c2}), .y({1'b0, p_cms2}),
    .out_valid(vec_valid), .mag(ya), .ang()
  );
  gcd_cordic_vector #(.ITER(CORDIC_ITERATIONS), .W(W), .DW(DW)) u_vec_cos (
    .clk(clk), .rst(rst), .in_valid(prod_valid),
    .x({1'b0, p_c1c2}), .y({1'b0, p_sms2}),
    .out_valid(), .mag(xa), .ang()
  );
  gcd_cordic_vector #(.ITER(CORDIC_ITERATIONS), .W(W), .DW(DW)) u_vec_ang (
    .clk(clk), .rst(rst), .in_valid(vec_valid), .x(xa), .y(ya),
    .out_valid(ang_valid), .mag(), .ang(ang)
  );

  gcd_umul_round #(.AW(W + 2), .BW(DIAM_W), .OW(FINAL_W), .SHIFT(W)) u_mul_dist (
    .clk(clk), .rst(rst), .in_valid(clamp_valid), .a(ang_pos), .b(DIAMETER_CM),
    .out_valid(dist_valid), .p(dist_raw)
  );

endmodule
